### src/gradient_non_max_suppression_macros.svh
// ============================================================================
// Assertion macros for the gradient non-maximum suppression block
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while reset is asserted.
// ============================================================================
`ifndef GRADIENT_NON_MAX_SUPPRESSION_MACROS_SVH
`define GRADIENT_NON_MAX_SUPPRESSION_MACROS_SVH

// Same-cycle implication
`define GNMS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define GNMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/gnms_pkg.sv
// ============================================================================
// gnms_pkg
// Field widths, register indexes and direction codes shared by the
// gradient non-maximum suppression block and its checker.
// ============================================================================
package gnms_pkg;

    // Payload field widths
    localparam int MAG_W      = 8;
    localparam int DIR_W      = 8;

    // Configuration register widths and port shape
    localparam int FW_BITS    = 11;
    localparam int FH_BITS    = 12;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    // Item kinds
    localparam logic OP_PIXEL = 1'b0;

    // Quantized direction codes
    localparam logic [DIR_W-1:0] DIR_0   = 8'd0;
    localparam logic [DIR_W-1:0] DIR_45  = 8'd45;
    localparam logic [DIR_W-1:0] DIR_90  = 8'd90;
    localparam logic [DIR_W-1:0] DIR_135 = 8'd135;

    // Neighbor value for unknown direction codes
    localparam logic [MAG_W-1:0] MAG_SAT = 8'd255;

endpackage

### src/gnms_ram.sv
// ============================================================================
// gnms_ram
// Generic single-write, single-read synchronous RAM with registered read
// data. Read data holds while no read is issued.
// ============================================================================
module gnms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### src/gradient_non_max_suppression.sv
// ============================================================================
// gradient_non_max_suppression
// Canny non-maximum suppression over a raster stream of gradient magnitude
// and quantized direction pixels, with line stores held in block RAM.
// ============================================================================
// The block takes one item per clock while in_stall is low. Each result
// passes the line store read into the stage one register, then the output
// register. in_stall rises only while the output register holds a result
// that the downstream side stalls, so throughput is set by the single read
// and write port of each line store, which every pixel uses once. Results
// lag pixels by one row plus one pixel; after the last pixel of a frame,
// width + 1 further items (flush or pixel, data ignored) drain the trailing
// border outputs, the last carrying frame_last. Flush items arriving before
// the frame is complete are dropped. A register write restarts the frame;
// write only while idle. Line store contents never written only ever feed
// border outputs, so no clearing pass runs after reset.
// ============================================================================
module gradient_non_max_suppression #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4095
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Input pixel channel
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             op,
    input  logic [gnms_pkg::MAG_W-1:0]       mag_value,
    input  logic [gnms_pkg::DIR_W-1:0]       direction,
    // Output pixel channel
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [gnms_pkg::MAG_W-1:0]       out_value,
    output logic                             frame_last,
    // Configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [gnms_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gnms_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int AW      = $clog2(MAX_WIDTH);
    localparam int WW      = $clog2(MAX_WIDTH + 1);
    localparam int HW      = $clog2(MAX_HEIGHT + 1);
    localparam int RESET_W = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
    localparam int RESET_H = (480 > MAX_HEIGHT) ? MAX_HEIGHT : 480;
    localparam int MW      = gnms_pkg::MAG_W;
    localparam int DW      = gnms_pkg::DIR_W;

    typedef struct packed {
        logic          pix;
        logic          emit;
        logic          interior;
        logic          last;
        logic [AW-1:0] addr;
        logic [MW-1:0] mag;
        logic [DW-1:0] dir;
    } stage_t;

    // Configuration and position state
    logic [WW-1:0]   w_eff_reg;
    logic [HW-1:0]   h_eff_reg;
    logic [WW-1:0]   col_reg;
    logic [WW-1:0]   col_next;
    logic [HW-1:0]   row_reg;
    logic [HW-1:0]   row_next;
    logic [WW-1:0]   w_clamp;
    logic [HW-1:0]   h_clamp;
    logic [31:0]     cfg_w32;
    logic [31:0]     cfg_h32;
    logic            cfg_xfer;

    // Pipeline control
    logic            adv;
    logic            in_xfer;
    logic            trailing;
    logic            is_pixel;
    logic            s0_valid;
    stage_t          s0;
    logic            s1_valid_reg;
    stage_t          s1_reg;

    // Line store ports
    logic            rd_en;
    logic            wr_en;
    logic [2*MW-1:0] mag_rdata;
    logic [2*MW-1:0] mag_wdata;
    logic [DW-1:0]   dir_rdata;
    logic [MW-1:0]   top;
    logic [MW-1:0]   mid;

    // Window: columns one and two of the 3x3 neighborhood
    logic [MW-1:0]   w01_reg;
    logic [MW-1:0]   w02_reg;
    logic [MW-1:0]   w11_reg;
    logic [MW-1:0]   w12_reg;
    logic [MW-1:0]   w21_reg;
    logic [MW-1:0]   w22_reg;
    logic [DW-1:0]   centre_dir_reg;
    logic [MW-1:0]   n1;
    logic [MW-1:0]   n2;
    logic [MW-1:0]   s1_value;

    // Output register
    logic            out_valid_reg;
    logic [MW-1:0]   out_value_reg;
    logic            frame_last_reg;

    // Handshakes
    assign adv       = !(out_valid_reg && out_stall);
    assign in_stall  = !adv;
    assign in_xfer   = in_valid && adv;
    assign cfg_ready = 1'b1;
    assign cfg_xfer  = cfg_valid && cfg_ready;

    // Clamp incoming register values to the supported frame size
    assign cfg_w32 = 32'(cfg_data[gnms_pkg::FW_BITS-1:0]);
    assign cfg_h32 = 32'(cfg_data[gnms_pkg::FH_BITS-1:0]);

    always_comb
    begin
        if (cfg_w32 < 32'd3)
        begin
            w_clamp = WW'(3);
        end
        else if (cfg_w32 > 32'(MAX_WIDTH))
        begin
            w_clamp = WW'(MAX_WIDTH);
        end
        else
        begin
            w_clamp = cfg_w32[WW-1:0];
        end

        if (cfg_h32 < 32'd3)
        begin
            h_clamp = HW'(3);
        end
        else if (cfg_h32 > 32'(MAX_HEIGHT))
        begin
            h_clamp = HW'(MAX_HEIGHT);
        end
        else
        begin
            h_clamp = cfg_h32[HW-1:0];
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_eff_reg <= WW'(RESET_W);
            h_eff_reg <= HW'(RESET_H);
        end
        else if (cfg_xfer)
        begin
            case (cfg_index)
                gnms_pkg::CFG_FRAME_WIDTH:  w_eff_reg <= w_clamp;
                gnms_pkg::CFG_FRAME_HEIGHT: h_eff_reg <= h_clamp;
                default: ;
            endcase
        end
    end

    // Classify the incoming item and build the stage one record
    assign trailing = (row_reg >= h_eff_reg);
    assign is_pixel = (op == gnms_pkg::OP_PIXEL);
    assign s0_valid = in_xfer && (trailing || is_pixel);
    assign rd_en    = in_xfer && !trailing && is_pixel;

    always_comb
    begin
        s0.pix      = !trailing;
        s0.emit     = trailing || (row_reg > HW'(1))
                      || ((row_reg == HW'(1)) && (col_reg != '0));
        s0.interior = !trailing && (row_reg > HW'(1)) && (col_reg > WW'(1));
        s0.last     = trailing && (col_reg == w_eff_reg);
        s0.addr     = col_reg[AW-1:0];
        s0.mag      = mag_value;
        s0.dir      = direction;
    end

    // Advance column and row; in the trailing phase the column counts drains
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (in_xfer)
        begin
            if (trailing)
            begin
                if (col_reg == w_eff_reg)
                begin
                    col_next = '0;
                    row_next = '0;
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end
            else if (is_pixel)
            begin
                if ((col_reg + 1'b1) == w_eff_reg)
                begin
                    col_next = '0;
                    row_next = row_reg + 1'b1;
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cfg_xfer)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Stage one: line store data arrives
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= s0_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s0_valid)
        begin
            s1_reg <= s0;
        end
    end

    // Line stores: magnitude entry holds {two rows up, one row up}
    assign top       = mag_rdata[2*MW-1:MW];
    assign mid       = mag_rdata[MW-1:0];
    assign wr_en     = adv && s1_valid_reg && s1_reg.pix;
    assign mag_wdata = {mid, s1_reg.mag};

    gnms_ram #(
        .WIDTH (2 * MW),
        .DEPTH (MAX_WIDTH)
    ) u_mag_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (s1_reg.addr),
        .wdata (mag_wdata),
        .re    (rd_en),
        .raddr (col_reg[AW-1:0]),
        .rdata (mag_rdata)
    );

    gnms_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_WIDTH)
    ) u_dir_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (s1_reg.addr),
        .wdata (s1_reg.dir),
        .re    (rd_en),
        .raddr (col_reg[AW-1:0]),
        .rdata (dir_rdata)
    );

    // Pick neighbors from the window as it stands after this pixel's shift
    always_comb
    begin
        case (centre_dir_reg)
            gnms_pkg::DIR_0:
            begin
                n1 = w11_reg;
                n2 = mid;
            end
            gnms_pkg::DIR_45:
            begin
                n1 = top;
                n2 = w21_reg;
            end
            gnms_pkg::DIR_90:
            begin
                n1 = w02_reg;
                n2 = w22_reg;
            end
            gnms_pkg::DIR_135:
            begin
                n1 = w01_reg;
                n2 = s1_reg.mag;
            end
            default:
            begin
                n1 = gnms_pkg::MAG_SAT;
                n2 = gnms_pkg::MAG_SAT;
            end
        endcase
    end

    // Keep the center only if it is a local maximum; border pixels give zero
    assign s1_value = (s1_reg.interior && (w12_reg >= n1) && (w12_reg >= n2))
                      ? w12_reg : '0;

    // Shift the window and latch the centre direction on each pixel
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            w01_reg        <= w02_reg;
            w02_reg        <= top;
            w11_reg        <= w12_reg;
            w12_reg        <= mid;
            w21_reg        <= w22_reg;
            w22_reg        <= s1_reg.mag;
            centre_dir_reg <= dir_rdata;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= s1_valid_reg && s1_reg.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s1_valid_reg)
        begin
            out_value_reg  <= s1_value;
            frame_last_reg <= s1_reg.last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_value  = out_value_reg;
    assign frame_last = frame_last_reg;

endmodule

### src/gnms_checker.sv
// ============================================================================
// gnms_checker
// Port-level checks on the gradient non-maximum suppression block, bound
// to the top level.
// ============================================================================
`include "gradient_non_max_suppression_macros.svh"

module gnms_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_stall,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic [gnms_pkg::MAG_W-1:0]  out_value,
    input  logic                        frame_last
);

    // Hold a stalled result
    `GNMS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_value) && $stable(frame_last), "stalled output changed")

    // Stall the input only behind a stalled result
    `GNMS_ASSERT_IMPLY(a_in_stall_cause, clk, rst_n, in_stall, out_valid && out_stall, "input stalled without a stalled result")

    // The last pixel of a frame is a border pixel
    `GNMS_ASSERT_IMPLY(a_last_border, clk, rst_n, out_valid && frame_last, out_value == '0, "frame_last on a nonzero pixel")

endmodule

bind gradient_non_max_suppression gnms_checker u_gnms_checker (.*);
